/* sv/dbde_pkg.sv */
// Shared types and constants for the debounced button duration editor.
// No dependencies; imported by every module of the block.
package dbde_pkg;

   localparam int BUTTON_COUNT = 3;
   localparam int PERIOD_W     = 10;
   localparam int DUR_W        = 7;
   localparam int MODE_W       = 3;
   localparam int DUR_COUNT    = 3;

   localparam logic [DUR_W-1:0]    DURATION_MAX  = 7'd99;
   localparam logic [DUR_W-1:0]    DURATION_MIN  = 7'd1;
   localparam logic [DUR_W-1:0]    RESET_RED     = 7'd5;
   localparam logic [DUR_W-1:0]    RESET_AMBER   = 7'd2;
   localparam logic [DUR_W-1:0]    RESET_GREEN   = 7'd3;
   localparam logic [PERIOD_W-1:0] RESET_PERIOD  = 10'd100;
   localparam logic                RESET_PRESSED = 1'b0;

   // button lanes
   localparam int BTN_MODE      = 0;
   localparam int BTN_INCREMENT = 1;
   localparam int BTN_COMMIT    = 2;

   // duration slots
   localparam logic [1:0] DUR_RED   = 2'd0;
   localparam logic [1:0] DUR_AMBER = 2'd1;
   localparam logic [1:0] DUR_GREEN = 2'd2;

   // editor modes
   localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RED    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_AMBER  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_GREEN  = 3'd4;

   // configuration register indexes
   localparam logic REG_REPEAT_PERIOD = 1'b0;
   localparam logic REG_PRESSED_LEVEL = 1'b1;

   typedef struct packed {
      logic              restart_pulse;
      logic              lights_off_pulse;
      logic [DUR_W-1:0]  green_time;
      logic [DUR_W-1:0]  amber_time;
      logic [DUR_W-1:0]  red_time;
      logic [DUR_W-1:0]  green_edit;
      logic [DUR_W-1:0]  amber_edit;
      logic [DUR_W-1:0]  red_edit;
      logic [MODE_W-1:0] current_mode;
   } dbde_result_type;

endpackage

/* sv/dbde_lane.sv */
// One debounce and auto-repeat lane: sample history, stable level and
// repeat counter of a single button. Depends on dbde_pkg.
module dbde_lane
   import dbde_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                level,
   input  logic                pressed_level,
   input  logic [PERIOD_W-1:0] repeat_period,
   output logic                fire
);

   logic [1:0]          hist_ff, hist_in;     // [1] older sample
   logic                stable_ff, stable_in;
   logic [PERIOD_W-1:0] count_ff, count_in;
   logic                agree;

   always_comb begin
      agree     = (hist_ff[1] == hist_ff[0]) && (hist_ff[0] == level);
      hist_in   = {hist_ff[0], level};
      stable_in = stable_ff;
      count_in  = count_ff;
      fire      = 1'b0;
      if (agree) begin
         if (stable_ff != level) begin
            stable_in = level;
            if (level == pressed_level) begin
               count_in = repeat_period;
               fire     = 1'b1;
            end
         end else if (count_ff <= PERIOD_W'(1)) begin
            count_in = repeat_period;
            fire     = (level == pressed_level);
         end else begin
            count_in = count_ff - PERIOD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff   <= {2{~RESET_PRESSED}};
         stable_ff <= ~RESET_PRESSED;
         count_ff  <= RESET_PERIOD;
      end else if (accept) begin
         hist_ff   <= hist_in;
         stable_ff <= stable_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/dbde_merge.sv */
// Merging stage: applies the lanes' actions in button order to the mode,
// the edit buffers and the committed durations. Depends on dbde_pkg.
module dbde_merge
   import dbde_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [BUTTON_COUNT-1:0] fire,
   output dbde_result_type         result
);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [DUR_W-1:0]  edit_ff [DUR_COUNT];
   logic [DUR_W-1:0]  edit_in [DUR_COUNT];
   logic [DUR_W-1:0]  time_ff [DUR_COUNT];
   logic [DUR_W-1:0]  time_in [DUR_COUNT];
   logic              lights, restart, editing;
   logic [1:0]        slot;
   logic [DUR_W:0]    bumped;

   always_comb begin
      mode_in = mode_ff;
      edit_in = edit_ff;
      time_in = time_ff;
      lights  = 1'b0;
      restart = 1'b0;
      editing = 1'b0;
      slot    = DUR_RED;
      bumped  = '0;

      if (fire[BTN_MODE]) begin
         case (mode_in) inside
            MODE_NORMAL, MODE_RED, MODE_AMBER: begin
               mode_in = mode_in + MODE_W'(1);
               edit_in = time_in;
               lights  = 1'b1;
            end
            MODE_GREEN: begin
               mode_in = MODE_NORMAL;
               edit_in = time_in;
               lights  = 1'b1;
               restart = 1'b1;
            end
            default: begin
               mode_in = MODE_NORMAL;
            end
         endcase
      end

      // mode is settled for the other two buttons
      case (mode_in)
         MODE_RED: begin
            editing = 1'b1;
            slot    = DUR_RED;
         end
         MODE_AMBER: begin
            editing = 1'b1;
            slot    = DUR_AMBER;
         end
         MODE_GREEN: begin
            editing = 1'b1;
            slot    = DUR_GREEN;
         end
         default: begin
            editing = 1'b0;
            slot    = DUR_RED;
         end
      endcase

      if (fire[BTN_INCREMENT] && editing) begin
         bumped = {1'b0, edit_in[slot]} + (DUR_W+1)'(1);
         if (bumped > {1'b0, DURATION_MAX}) begin
            edit_in[slot] = DURATION_MIN;
         end else begin
            edit_in[slot] = bumped[DUR_W-1:0];
         end
      end

      if (fire[BTN_COMMIT] && editing) begin
         time_in[slot] = edit_in[slot];
      end

      result.current_mode     = mode_in;
      result.red_edit         = edit_in[DUR_RED];
      result.amber_edit       = edit_in[DUR_AMBER];
      result.green_edit       = edit_in[DUR_GREEN];
      result.red_time         = time_in[DUR_RED];
      result.amber_time       = time_in[DUR_AMBER];
      result.green_time       = time_in[DUR_GREEN];
      result.lights_off_pulse = lights;
      result.restart_pulse    = restart;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= MODE_NORMAL;
         edit_ff[DUR_RED]   <= RESET_RED;
         edit_ff[DUR_AMBER] <= RESET_AMBER;
         edit_ff[DUR_GREEN] <= RESET_GREEN;
         time_ff[DUR_RED]   <= RESET_RED;
         time_ff[DUR_AMBER] <= RESET_AMBER;
         time_ff[DUR_GREEN] <= RESET_GREEN;
      end else if (accept) begin
         mode_ff <= mode_in;
         edit_ff <= edit_in;
         time_ff <= time_in;
      end
   end

endmodule

/* sv/dbde_out_buf.sv */
// Two-entry output buffer (output register plus skid register) that parts
// the result channel from the input side. Depends on dbde_pkg.
module dbde_out_buf
   import dbde_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  dbde_result_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output dbde_result_type out_data
);

   dbde_result_type out_ff, out_in, skid_ff, skid_in;
   logic            out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic            take, push;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_comb begin
      take          = out_valid_ff && out_ready;
      push          = in_valid && !skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_in       = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

/* sv/debounced_button_duration_editor_top.sv */
// Debounced three-button duration editor, top level.
// A req_ result is registered in the output register, or in the skid register if that one holds an untaken result.
// Throughput: one item per cycle; the two-entry output buffer keeps
// req_tready high unless both of its entries hold untaken results.
// Reset (synchronous): buttons released, mode normal, durations 5/2/3,
// repeat period 100, pressed level 0. Depends on dbde_pkg and submodules.
module debounced_button_duration_editor_top
   import dbde_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // [0] mode_button_level, [1] increment_button_level,
   // [2] commit_button_level, [7:3] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // [2:0] current_mode, [9:3] red_edit, [16:10] amber_edit,
   // [23:17] green_edit, [30:24] red_time, [37:31] amber_time,
   // [44:38] green_time, [45] lights_off_pulse, [46] restart_pulse, [47] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [PERIOD_W-1:0]     period_ff;
   logic                    pressed_ff;
   logic                    accept;
   logic [BUTTON_COUNT-1:0] fire;
   dbde_result_type         result, rsp_result;
   logic                    csr_write;
   logic                    reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (reg_sel)
         REG_REPEAT_PERIOD: csr_prdata = {{(32-PERIOD_W){1'b0}}, period_ff};
         REG_PRESSED_LEVEL: csr_prdata = {31'b0, pressed_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= RESET_PERIOD;
         pressed_ff <= RESET_PRESSED;
      end else if (csr_write) begin
         case (reg_sel)
            REG_REPEAT_PERIOD: period_ff  <= csr_pwdata[PERIOD_W-1:0];
            REG_PRESSED_LEVEL: pressed_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   assign accept = req_tvalid && req_tready;

   for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_lane
      dbde_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .accept        (accept),
         .level         (req_tdata[b]),
         .pressed_level (pressed_ff),
         .repeat_period (period_ff),
         .fire          (fire[b])
      );
   end

   dbde_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .fire   (fire),
      .result (result)
   );

   dbde_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = {1'b0, rsp_result};

endmodule

/* dv/duration_editor_checker.sv */
`timescale 1ns / 1ps
// Checker for the debounced button duration editor: watches the req_, rsp_ and csr_ ports,
// predicts one result per tick transfer and compares it field by field.
// Depends on dbde_pkg for the result layout and the mode and button codes.
module duration_editor_checker
   import dbde_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          results_pending
);

   // configuration copy
   logic [PERIOD_W-1:0] period_cfg;
   logic                pressed_cfg;

   // editor state copy
   logic [2:0]          sample_hist [BUTTON_COUNT];
   logic                stable_lvl  [BUTTON_COUNT];
   logic [PERIOD_W-1:0] repeat_cnt  [BUTTON_COUNT];
   logic [MODE_W-1:0]   mode;
   logic [DUR_W-1:0]    edit_buf    [DUR_COUNT];
   logic [DUR_W-1:0]    committed   [DUR_COUNT];
   logic                lights_flag;
   logic                restart_flag;

   dbde_result_type     results_due [$];
   dbde_result_type     got_result;
   dbde_result_type     tick_result;

   initial begin
      mismatch_count  = 0;
      results_pending = 0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input longint got, input longint want);
      if (got != want) begin
         report_mismatch(what, got, want);
      end
   endtask

   task automatic clear_state();
      period_cfg  = RESET_PERIOD;
      pressed_cfg = RESET_PRESSED;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
         sample_hist[b] = {3{~RESET_PRESSED}};
         stable_lvl[b]  = ~RESET_PRESSED;
         repeat_cnt[b]  = RESET_PERIOD;
      end
      mode         = MODE_NORMAL;
      committed[0] = RESET_RED;
      committed[1] = RESET_AMBER;
      committed[2] = RESET_GREEN;
      edit_buf     = committed;
      results_due.delete();
   endtask

   task automatic apply_action(input int btn);
      logic [1:0] slot;
      logic [7:0] sum;
      slot = 2'(mode - MODE_RED);
      case (btn)
         BTN_MODE: begin
            if (mode >= MODE_NORMAL && mode <= MODE_GREEN) begin
               if (mode == MODE_GREEN) begin
                  restart_flag = 1'b1;
                  mode = MODE_NORMAL;
               end else begin
                  mode = mode + 1'b1;
               end
               edit_buf    = committed;
               lights_flag = 1'b1;
            end else begin
               mode = MODE_NORMAL;
            end
         end
         BTN_INCREMENT: begin
            if (mode >= MODE_RED && mode <= MODE_GREEN) begin
               // widened so the compare sees the carry before the wrap
               sum = {1'b0, edit_buf[slot]} + 8'd1;
               if (sum > {1'b0, DURATION_MAX}) begin
                  sum = {1'b0, DURATION_MIN};
               end
               edit_buf[slot] = sum[DUR_W-1:0];
            end
         end
         BTN_COMMIT: begin
            if (mode >= MODE_RED && mode <= MODE_GREEN) begin
               committed[slot] = edit_buf[slot];
            end
         end
         default: ;
      endcase
   endtask

   task automatic predict_tick(input logic [2:0] levels, output dbde_result_type r);
      logic lvl;
      lights_flag  = 1'b0;
      restart_flag = 1'b0;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
         lvl = levels[b];
         sample_hist[b] = {sample_hist[b][1:0], lvl};
         if (sample_hist[b] == 3'b000 || sample_hist[b] == 3'b111) begin
            if (stable_lvl[b] != lvl) begin
               stable_lvl[b] = lvl;
               // a stable release leaves the counter alone
               if (lvl == pressed_cfg) begin
                  repeat_cnt[b] = period_cfg;
                  apply_action(b);
               end
            end else if (repeat_cnt[b] <= 1) begin
               repeat_cnt[b] = period_cfg;
               if (lvl == pressed_cfg) begin
                  apply_action(b);
               end
            end else begin
               repeat_cnt[b] = repeat_cnt[b] - 1'b1;
            end
         end
      end
      r.current_mode     = mode;
      r.red_edit         = edit_buf[0];
      r.amber_edit       = edit_buf[1];
      r.green_edit       = edit_buf[2];
      r.red_time         = committed[0];
      r.amber_time       = committed[1];
      r.green_time       = committed[2];
      r.lights_off_pulse = lights_flag;
      r.restart_pulse    = restart_flag;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         // a result never leaves in the cycle its tick is taken, so compare first
         if (rsp_tvalid && rsp_tready) begin
            got_result = dbde_result_type'(rsp_tdata[46:0]);
            check_field("padding bit", rsp_tdata[47], 0);
            if (results_due.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 0);
            end else begin
               tick_result = results_due.pop_front();
               check_field("current_mode", got_result.current_mode, tick_result.current_mode);
               check_field("red_edit", got_result.red_edit, tick_result.red_edit);
               check_field("amber_edit", got_result.amber_edit, tick_result.amber_edit);
               check_field("green_edit", got_result.green_edit, tick_result.green_edit);
               check_field("red_time", got_result.red_time, tick_result.red_time);
               check_field("amber_time", got_result.amber_time, tick_result.amber_time);
               check_field("green_time", got_result.green_time, tick_result.green_time);
               check_field("lights_off_pulse", got_result.lights_off_pulse,
                           tick_result.lights_off_pulse);
               check_field("restart_pulse", got_result.restart_pulse,
                           tick_result.restart_pulse);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_tick(req_tdata[2:0], tick_result);
            results_due.push_back(tick_result);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[1:0] == 2'b00) begin
            if (csr_paddr[2] == REG_REPEAT_PERIOD) begin
               period_cfg = csr_pwdata[PERIOD_W-1:0];
            end else if (csr_paddr[2] == REG_PRESSED_LEVEL) begin
               pressed_cfg = csr_pwdata[0];
            end
         end
      end
      results_pending <= results_due.size();
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Top of the duration editor testbench: clock, reset, button stimulus, register
// writes and the verdict. Needs dbde_pkg, the block's RTL and duration_editor_checker.
module testbench
   import dbde_pkg::*;
();

   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_ITEMS = 190;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int results_pending;
   int cycle_count = 0;
   int items_sent = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   logic pressed_now = RESET_PRESSED;

   // per-phase settings; extremes of the period and both pressed levels
   int unsigned period_tab  [8] = '{0, 1, 3, 1023, 2, 7, 5, 0};
   logic        pressed_tab [8] = '{0, 1, 0, 1, 0, 1, 0, 1};
   int          send_idle_tab [4] = '{0, 84, 0, 38};
   int          stall_tab     [4] = '{0, 0, 84, 38};

   debounced_button_duration_editor_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   duration_editor_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input logic [2:0] levels);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, levels};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   // mask bit set = button pressed, whatever the pressed level is
   task automatic hold(input logic [2:0] pressed_mask, input int ticks);
      repeat (ticks) send_item(pressed_mask ^ {3{~pressed_now}});
   endtask

   task automatic csr_write(input logic reg_idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input int quota);
      int start;
      int pick;
      start = items_sent;
      while (items_sent - start < quota) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            // walk to an edit mode, bump its buffer, commit it
            hold(3'b000, 3);
            repeat ($urandom_range(1, 4)) begin
               hold(3'b001, $urandom_range(3, 5));
               hold(3'b000, $urandom_range(3, 4));
            end
            hold(3'b010, $urandom_range(3, 110));
            hold(3'b000, 3);
            hold(3'b100, $urandom_range(3, 6));
            hold(3'b000, 3);
         end else if (pick < 80) begin
            repeat (10) hold(3'($urandom_range(0, 7)), $urandom_range(1, 12));
         end else begin
            repeat (20) send_item(3'($urandom_range(0, 7)));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: single presses, a glitch, and all three at once
      hold(3'b001, 3);
      hold(3'b000, 1);
      hold(3'b001, 1);
      hold(3'b000, 3);
      hold(3'b010, 3);
      hold(3'b000, 3);
      hold(3'b100, 3);
      hold(3'b000, 3);
      hold(3'b111, 3);
      hold(3'b000, 3);

      for (int ph = 0; ph < 8; ph++) begin
         drain();
         csr_write(REG_REPEAT_PERIOD, ($urandom() << PERIOD_W) | period_tab[ph]);
         csr_write(REG_PRESSED_LEVEL, ($urandom() << 1) | pressed_tab[ph]);
         pressed_now   = pressed_tab[ph];
         send_idle_pct = send_idle_tab[ph % 4];
         stall_pct     = stall_tab[ph % 4];
         run_phase(PHASE_ITEMS);
      end

      req_tvalid <= 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      while (results_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
